// ===== rtl/ssc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared types for the sphere-sphere contact unit.
// ----------------------------------------------------------------------------
package ssc_pkg;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_RADA  = 9'b000000010,
		ST_RADB  = 9'b000000100,
		ST_SQR   = 9'b000001000,
		ST_ROOT  = 9'b000010000,
		ST_DIV   = 9'b000100000,
		ST_OFFA  = 9'b001000000,
		ST_OFFB  = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

endpackage

// ===== rtl/sphere_sphere_contact.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_sphere_contact
// Sphere-sphere contact: stores a first body, computes contact on the second.
// For a second body the square root takes one bit per cycle, there are three
// normal divides, and one shared multiplier serves all products; coincident
// centers skip the divides. busy is high for the whole item; no next item until done.
// Reset clears the stored body and the sequencer; results cannot be stalled.
// ----------------------------------------------------------------------------
module sphere_sphere_contact import ssc_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic signed [COORD_WIDTH-1:0] center_x,
	input  logic signed [COORD_WIDTH-1:0] center_y,
	input  logic signed [COORD_WIDTH-1:0] center_z,
	input  logic signed [COORD_WIDTH-1:0] position_x,
	input  logic signed [COORD_WIDTH-1:0] position_y,
	input  logic signed [COORD_WIDTH-1:0] position_z,
	input  logic [COORD_WIDTH-2:0]        radius,
	input  logic signed [COORD_WIDTH-1:0] scale_x,
	output logic                          strobe,
	output logic signed [COORD_WIDTH-1:0] contact_a_x,
	output logic signed [COORD_WIDTH-1:0] contact_a_y,
	output logic signed [COORD_WIDTH-1:0] contact_a_z,
	output logic signed [COORD_WIDTH-1:0] contact_b_x,
	output logic signed [COORD_WIDTH-1:0] contact_b_y,
	output logic signed [COORD_WIDTH-1:0] contact_b_z,
	output logic signed [COORD_WIDTH-1:0] depth,
	output logic signed [FRAC_BITS+1:0]   normal_x,
	output logic signed [FRAC_BITS+1:0]   normal_y,
	output logic signed [FRAC_BITS+1:0]   normal_z,
	output logic                          has_collision,
	output logic                          degenerate
);
	localparam int W  = COORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int NW = F + 2;
	localparam int SW = 2 * W + 2;
	localparam int RW = W + 1;
	localparam int CW = $clog2(2 * W + 2);
	localparam logic signed [W+1:0] CMAX = (W+2)'((64'sd1 <<< (W-1)) - 1);
	localparam logic signed [W+1:0] CMIN = -CMAX - (W+2)'(1);

	function automatic logic signed [W-1:0] sat(input logic signed [W+1:0] v);
		if (v > CMAX) return CMAX[W-1:0];
		if (v < CMIN) return CMIN[W-1:0];
		return v[W-1:0];
	endfunction

	state_t                  st_q;
	logic [CW-1:0]           cnt_q;
	logic [1:0]              ax_q;
	logic                    kind_q, loaded_q, wait_q;
	logic signed [W-1:0]     fc_q [3];
	logic signed [W-1:0]     fr_q, ob_q [3];
	logic signed [W:0]       d_q [3];
	logic [W-2:0]            rad_q;
	logic [W:0]              sc_q;
	logic [W-1:0]            ra_q, rb_q;
	logic [SW-1:0]           sum_q, rem_q;
	logic [RW-1:0]           len_q;
	logic [RW+1:0]           drem_q;
	logic [NW-1:0]           q_q, nm_q [3];
	logic signed [W-1:0]     ca_q [3], cb_q [3];

	logic [W:0]              ma, mb;
	logic [2*W+1:0]          prod;
	logic [RW+1:0]           dsh;
	logic [W-1:0]            pf;
	logic [SW+1:0]           rtry;

	ssc_mul #(.W(W + 1)) u_mul (.clk(clk), .a(ma), .b(mb), .p(prod));

	function automatic logic [W:0] mag(input logic signed [W:0] v);
		return v[W] ? (W+1)'(-v) : v;
	endfunction

	// scale product to frac and saturate
	always_comb begin
		if (|prod[2*W+1:W-1+F]) pf = CMAX[W-1:0];
		else pf = prod[W-1+F:F];
	end

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (st_q)
			ST_RADA, ST_RADB: begin
				ma = (W+1)'(rad_q);
				mb = sc_q;
			end
			ST_SQR: begin
				ma = mag(d_q[ax_q]);
				mb = mag(d_q[ax_q]);
			end
			ST_OFFA: begin
				ma = (W+1)'(nm_q[ax_q]);
				mb = (W+1)'(ra_q);
			end
			ST_OFFB: begin
				ma = (W+1)'(nm_q[ax_q]);
				mb = (W+1)'(rb_q);
			end
			default: ;
		endcase
	end

	assign dsh  = {drem_q[RW:0], 1'b0};
	// trial square: rem - (4*root + 1) at current bit pair
	assign rtry = {rem_q, sum_q[SW-1 -: 2]} - (SW+2)'({len_q, 2'b01});

	logic signed [W+1:0] offs;
	logic                nneg;
	assign nneg = d_q[ax_q][W];
	assign offs = nneg ? -(W+2)'($signed({1'b0, pf})) : (W+2)'($signed({1'b0, pf}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			loaded_q <= 1'b0;
			strobe   <= 1'b0;
			cnt_q    <= '0;
			ax_q     <= '0;
			wait_q   <= 1'b0;
			fr_q     <= '0;
			for (int i = 0; i < 3; i++) fc_q[i] <= '0;
		end else begin
			strobe <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (start) begin
						kind_q <= kind;
						rad_q  <= radius;
						sc_q   <= mag({scale_x[W-1], scale_x});
						ob_q[0] <= sat((W+2)'(center_x) + (W+2)'(position_x));
						ob_q[1] <= sat((W+2)'(center_y) + (W+2)'(position_y));
						ob_q[2] <= sat((W+2)'(center_z) + (W+2)'(position_z));
						wait_q <= 1'b0;
						st_q   <= (kind && !loaded_q) ? ST_IDLE : ST_RADA;
					end
				end
				ST_RADA: begin
					wait_q <= 1'b1;
					if (wait_q) begin
						wait_q <= 1'b0;
						if (!kind_q) begin
							fr_q     <= pf;
							loaded_q <= 1'b1;
							for (int i = 0; i < 3; i++) fc_q[i] <= ob_q[i];
							st_q <= ST_IDLE;
						end else begin
							rb_q <= pf;
							ra_q <= fr_q;
							for (int i = 0; i < 3; i++)
								d_q[i] <= (W+1)'(fc_q[i]) - (W+1)'(ob_q[i]);
							sum_q <= '0;
							ax_q  <= '0;
							cnt_q <= '0;
							st_q  <= ST_SQR;
						end
					end
				end
				ST_RADB: st_q <= ST_IDLE;
				ST_SQR: begin
					// issue three squares, accumulate each in the cycle after
					if (cnt_q != '0) sum_q <= sum_q + SW'(prod);
					cnt_q <= cnt_q + 1'b1;
					if (ax_q != 2'd2) ax_q <= ax_q + 1'b1;
					if (cnt_q == CW'(3)) begin
						rem_q <= '0;
						len_q <= '0;
						cnt_q <= '0;
						st_q  <= ST_ROOT;
					end
				end
				ST_ROOT: begin
					// one result bit per cycle
					sum_q <= {sum_q[SW-3:0], 2'b00};
					if (!rtry[SW+1]) begin
						rem_q <= rtry[SW-1:0];
						len_q <= {len_q[RW-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[SW-3:0], sum_q[SW-1 -: 2]};
						len_q <= {len_q[RW-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'((SW + 1) / 2 - 1)) begin
						cnt_q <= '0;
						ax_q  <= '0;
						st_q  <= ST_DIV;
						wait_q <= 1'b0;
					end
				end
				ST_DIV: begin
					if (len_q == '0) begin
						for (int i = 0; i < 3; i++) nm_q[i] <= '0;
						ax_q <= '0;
						wait_q <= 1'b0;
						st_q <= ST_OFFA;
					end else if (!wait_q) begin
						drem_q <= (RW+2)'(mag(d_q[ax_q]));
						q_q    <= '0;
						cnt_q  <= '0;
						wait_q <= 1'b1;
					end else begin
						logic [RW+1:0] t;
						t = (cnt_q == '0) ? drem_q : dsh;
						if (t >= (RW+2)'(len_q)) begin
							drem_q <= t - (RW+2)'(len_q);
							q_q    <= {q_q[NW-2:0], 1'b1};
						end else begin
							drem_q <= t;
							q_q    <= {q_q[NW-2:0], 1'b0};
						end
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == CW'(F)) begin
							wait_q <= 1'b0;
							nm_q[ax_q] <= {q_q[NW-2:0], (t >= (RW+2)'(len_q))};
							if (ax_q == 2'd2) begin
								ax_q <= '0;
								st_q <= ST_OFFA;
							end else ax_q <= ax_q + 1'b1;
						end
					end
				end
				ST_OFFA: begin
					wait_q <= ~wait_q;
					if (wait_q) begin
						ca_q[ax_q] <= sat((W+2)'(fc_q[ax_q]) - offs);
						st_q <= ST_OFFB;
					end
				end
				ST_OFFB: begin
					wait_q <= ~wait_q;
					if (wait_q) begin
						cb_q[ax_q] <= sat((W+2)'(ob_q[ax_q]) + offs);
						if (ax_q == 2'd2) st_q <= ST_DONE;
						else begin
							ax_q <= ax_q + 1'b1;
							st_q <= ST_OFFA;
						end
					end
				end
				ST_DONE: begin
					strobe <= 1'b1;
					st_q   <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	logic signed [W+2:0] dep;
	assign dep = (W+3)'(ra_q) + (W+3)'(rb_q) - (W+3)'(len_q);

	always_ff @(posedge clk) begin
		if (st_q == ST_DONE) begin
			contact_a_x <= ca_q[0];
			contact_a_y <= ca_q[1];
			contact_a_z <= ca_q[2];
			contact_b_x <= cb_q[0];
			contact_b_y <= cb_q[1];
			contact_b_z <= cb_q[2];
			normal_x <= d_q[0][W] ? -$signed(nm_q[0]) : $signed(nm_q[0]);
			normal_y <= d_q[1][W] ? -$signed(nm_q[1]) : $signed(nm_q[1]);
			normal_z <= d_q[2][W] ? -$signed(nm_q[2]) : $signed(nm_q[2]);
			depth <= sat(dep[W+1:0]);
			has_collision <= (dep > 0);
			degenerate <= (len_q == '0);
		end
	end

	assign busy = (st_q != ST_IDLE);

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(st_q))
		else $error("state not one-hot");
	a_strobe_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> st_q == ST_IDLE) else $error("strobe outside idle");
	a_strobe_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> loaded_q) else $error("result without first body");
	a_degen_normal: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && degenerate) |-> (normal_x == '0 && normal_y == '0 && normal_z == '0))
		else $error("degenerate with nonzero normal");
endmodule

// ===== rtl/ssc_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssc_mul
// Shared unsigned multiplier, one registered product per cycle.
// ----------------------------------------------------------------------------
module ssc_mul import ssc_pkg::*; #(
	parameter int W = 32
) (
	input  logic           clk,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic [2*W-1:0] p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule
